// ===== rtl/qte_pkg.sv =====
package qte_pkg;

    localparam int IN_W             = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TERM_W           = 36;
    localparam int CORD_W           = 38;
    localparam int ACC_W            = 32;
    localparam int MAG_W            = 28;
    localparam int ROOT_W           = 29;
    localparam int RAD_W            = 58;
    localparam int LEG_LAT          = ROOT_W + 2;

    localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [TERM_W-1:0] ONE_Q28     = TERM_W'(36'd268435456);
    localparam logic [RAD_W-1:0] ONE_Q56      = RAD_W'(1) << 56;

    typedef logic signed [IN_W-1:0]   comp_t;
    typedef logic signed [2*IN_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;

    typedef struct packed {
        term_t siny;
        term_t cosy;
        term_t sinr;
        term_t cosr;
        term_t sinp;
    } terms_t;

    typedef struct packed {
        term_t siny;
        term_t cosy;
        term_t sinr;
        term_t cosr;
    } vec_pair_t;

    typedef struct packed {
        logic clamped;
        logic negative;
    } pitch_flags_t;

    function automatic logic [ACC_W-1:0] atan_tab(input logic [4:0] k);
        logic [ACC_W-1:0] r;
        case (k)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            5'd24:   r = 32'd41;
            5'd25:   r = 32'd20;
            5'd26:   r = 32'd10;
            5'd27:   r = 32'd5;
            5'd28:   r = 32'd3;
            5'd29:   r = 32'd1;
            5'd30:   r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/qte_if.sv =====
interface qte_quat_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   quat_w;
    logic signed [15:0]   quat_x;
    logic signed [15:0]   quat_y;
    logic signed [15:0]   quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if #(parameter int ANGLE_BITS = qte_pkg::ANGLE_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic                         pitch_clamped;

    modport source (output valid, yaw_angle, pitch_angle, roll_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, pitch_clamped,
                    output ready);
endinterface

// ===== rtl/qte_products.sv =====
module qte_products (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  qte_pkg::comp_t         w,
    input  qte_pkg::comp_t         x,
    input  qte_pkg::comp_t         y,
    input  qte_pkg::comp_t         z,
    output logic                   out_valid,
    output qte_pkg::terms_t        terms
);

    localparam int TW = qte_pkg::TERM_W;

    qte_pkg::prod_t wz_reg, xy_reg, yy_reg, zz_reg, wx_reg, yz_reg, xx_reg, wy_reg, zx_reg;
    qte_pkg::terms_t terms_reg, terms_next;
    logic prod_valid_reg, terms_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            terms_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg  <= in_valid;
            terms_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wz_reg <= w * z;
            xy_reg <= x * y;
            yy_reg <= y * y;
            zz_reg <= z * z;
            wx_reg <= w * x;
            yz_reg <= y * z;
            xx_reg <= x * x;
            wy_reg <= w * y;
            zx_reg <= z * x;
            terms_reg <= terms_next;
        end
    end

    always_comb
    begin
        terms_next.siny = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        terms_next.cosy = qte_pkg::ONE_Q28 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        terms_next.sinr = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        terms_next.cosr = qte_pkg::ONE_Q28 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        terms_next.sinp = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
    end

    assign out_valid = terms_valid_reg;
    assign terms     = terms_reg;

endmodule

// ===== rtl/qte_asin_leg.sv =====
module qte_asin_leg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  qte_pkg::term_t                sinp,
    output logic                          out_valid,
    output qte_pkg::term_t                sinp_out,
    output logic [qte_pkg::ROOT_W-1:0]    cos_leg,
    output qte_pkg::pitch_flags_t         flags
);

    localparam int RW = qte_pkg::RAD_W;
    localparam int NR = qte_pkg::ROOT_W;
    localparam int MW = qte_pkg::MAG_W;

    qte_pkg::term_t        mag;
    logic [2*MW-1:0]       mag_sq_reg;
    qte_pkg::term_t        sinp_a_reg;
    qte_pkg::pitch_flags_t flags_a_reg;
    logic                  valid_a_reg;

    logic [RW-1:0]         rad_reg   [0:NR];
    logic [NR-1:0]         root_reg  [0:NR];
    qte_pkg::term_t        sp_reg    [0:NR];
    qte_pkg::pitch_flags_t fl_reg    [0:NR];
    logic [NR:0]           vld_reg;

    assign mag = sinp[qte_pkg::TERM_W-1] ? -sinp : sinp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            vld_reg[0]  <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            vld_reg[0]  <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_sq_reg           <= mag[MW-1:0] * mag[MW-1:0];
            sinp_a_reg           <= sinp;
            flags_a_reg.clamped  <= (mag >= qte_pkg::ONE_Q28);
            flags_a_reg.negative <= sinp[qte_pkg::TERM_W-1];
            rad_reg[0]           <= qte_pkg::ONE_Q56 - RW'(mag_sq_reg);
            root_reg[0]          <= '0;
            sp_reg[0]            <= sinp_a_reg;
            fl_reg[0]            <= flags_a_reg;
        end
    end

    for (genvar s = 0; s < NR; s++)
    begin : g_root
        localparam int B = NR - 1 - s;
        logic [RW-1:0] trial;
        logic [RW-1:0] rad_next;
        logic [NR-1:0] root_next;

        always_comb
        begin
            trial = (RW'(root_reg[s]) << (B + 1)) | (RW'(1) << (2 * B));
            if (rad_reg[s] >= trial)
            begin
                rad_next  = rad_reg[s] - trial;
                root_next = root_reg[s] | (NR'(1) << B);
            end
            else
            begin
                rad_next  = rad_reg[s];
                root_next = root_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1]  <= rad_next;
                root_reg[s+1] <= root_next;
                sp_reg[s+1]   <= sp_reg[s];
                fl_reg[s+1]   <= fl_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[NR];
    assign sinp_out  = sp_reg[NR];
    assign cos_leg   = root_reg[NR];
    assign flags     = fl_reg[NR];

endmodule

// ===== rtl/qte_cordic.sv =====
module qte_cordic #(
    parameter int ANGLE_BITS   = qte_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [qte_pkg::CORD_W-1:0] y_in,
    input  logic signed [qte_pkg::CORD_W-1:0] x_in,
    input  qte_pkg::pitch_flags_t            side_in,
    output logic                             out_valid,
    output logic [ANGLE_BITS-1:0]            angle,
    output qte_pkg::pitch_flags_t            side_out
);

    localparam int CW = qte_pkg::CORD_W;
    localparam int AW = qte_pkg::ACC_W;
    localparam int SH = AW - ANGLE_BITS;

    logic signed [CW-1:0]  x_reg    [0:CORDIC_STEPS];
    logic signed [CW-1:0]  y_reg    [0:CORDIC_STEPS];
    logic [AW-1:0]         acc_reg  [0:CORDIC_STEPS];
    logic                  zero_reg [0:CORDIC_STEPS];
    qte_pkg::pitch_flags_t side_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] vld_reg;

    logic [AW-1:0]         final_acc;
    logic [ANGLE_BITS-1:0] angle_next, angle_reg;
    qte_pkg::pitch_flags_t side_out_reg;
    logic                  out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0]    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0]    <= in_valid;
            out_valid_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                x_reg[0]   <= -x_in;
                y_reg[0]   <= -y_in;
                acc_reg[0] <= qte_pkg::HALF_TURN;
            end
            else
            begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                acc_reg[0] <= '0;
            end
            zero_reg[0]  <= (x_in == 0) && (y_in == 0);
            side_reg[0]  <= side_in;
            angle_reg    <= angle_next;
            side_out_reg <= side_reg[CORDIC_STEPS];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] x_next, y_next;
        logic [AW-1:0]        acc_next;

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                x_next   = x_reg[i] + (y_reg[i] >>> i);
                y_next   = y_reg[i] - (x_reg[i] >>> i);
                acc_next = acc_reg[i] + qte_pkg::atan_tab(5'(i));
            end
            else
            begin
                x_next   = x_reg[i] - (y_reg[i] >>> i);
                y_next   = y_reg[i] + (x_reg[i] >>> i);
                acc_next = acc_reg[i] - qte_pkg::atan_tab(5'(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                acc_reg[i+1]  <= acc_next;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_comb
    begin
        if (side_reg[CORDIC_STEPS].clamped)
            final_acc = side_reg[CORDIC_STEPS].negative ? -qte_pkg::QUARTER_TURN
                                                        : qte_pkg::QUARTER_TURN;
        else if (zero_reg[CORDIC_STEPS])
            final_acc = '0;
        else
            final_acc = acc_reg[CORDIC_STEPS];
    end

    if (SH > 0)
    begin : g_round
        logic [AW-1:0] rounded;
        assign rounded    = final_acc + (AW'(1) << (SH - 1));
        assign angle_next = rounded[AW-1:SH];
    end
    else
    begin : g_noround
        assign angle_next = final_acc[ANGLE_BITS-1:0];
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Channel    Modport  Payload
// quat_in    sink     quat_w, quat_x, quat_y, quat_z (signed Q2.14)
// euler_out  source   yaw_angle, pitch_angle, roll_angle, pitch_clamped
//
// One item per cycle while euler_out is not stalled. The stages, in order:
// products and terms, the arcsine cosine leg (square root, one bit per stage),
// then three CORDIC pipelines in lockstep with a rounding output register.
// Reset clears only valid bits. A stall at the output holds every stage.
module quaternion_to_euler_angles #(
    parameter int ANGLE_BITS   = qte_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    qte_quat_if.sink        quat_in,
    qte_euler_if.source     euler_out
);

    localparam int CW = qte_pkg::CORD_W;
    localparam int LL = qte_pkg::LEG_LAT;
    localparam logic [ANGLE_BITS-1:0] Q_CODE = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic                  adv;
    logic                  terms_valid;
    qte_pkg::terms_t       terms;
    logic                  leg_valid;
    qte_pkg::term_t        sinp_d;
    logic [qte_pkg::ROOT_W-1:0] cos_leg;
    qte_pkg::pitch_flags_t flags;
    qte_pkg::vec_pair_t    dly_reg [0:LL-1];
    qte_pkg::pitch_flags_t no_side, pitch_side, yaw_side, roll_side;
    logic                  yaw_valid, pitch_valid, roll_valid;
    logic [ANGLE_BITS-1:0] yaw, pitch, roll;

    assign adv           = !yaw_valid || euler_out.ready;
    assign quat_in.ready = adv;
    assign no_side       = '0;

    qte_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (quat_in.valid),
        .w         (quat_in.quat_w),
        .x         (quat_in.quat_x),
        .y         (quat_in.quat_y),
        .z         (quat_in.quat_z),
        .out_valid (terms_valid),
        .terms     (terms)
    );

    qte_asin_leg u_asin_leg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (terms_valid),
        .sinp      (terms.sinp),
        .out_valid (leg_valid),
        .sinp_out  (sinp_d),
        .cos_leg   (cos_leg),
        .flags     (flags)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0].siny <= terms.siny;
            dly_reg[0].cosy <= terms.cosy;
            dly_reg[0].sinr <= terms.sinr;
            dly_reg[0].cosr <= terms.cosr;
            for (int k = 1; k < LL; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (leg_valid),
        .y_in      (CW'(dly_reg[LL-1].siny)),
        .x_in      (CW'(dly_reg[LL-1].cosy)),
        .side_in   (no_side),
        .out_valid (yaw_valid),
        .angle     (yaw),
        .side_out  (yaw_side)
    );

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (leg_valid),
        .y_in      (CW'(sinp_d)),
        .x_in      (CW'($signed({1'b0, cos_leg}))),
        .side_in   (flags),
        .out_valid (pitch_valid),
        .angle     (pitch),
        .side_out  (pitch_side)
    );

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (leg_valid),
        .y_in      (CW'(dly_reg[LL-1].sinr)),
        .x_in      (CW'(dly_reg[LL-1].cosr)),
        .side_in   (no_side),
        .out_valid (roll_valid),
        .angle     (roll),
        .side_out  (roll_side)
    );

    assign euler_out.valid         = yaw_valid;
    assign euler_out.yaw_angle     = yaw;
    assign euler_out.pitch_angle   = pitch;
    assign euler_out.roll_angle    = roll;
    assign euler_out.pitch_clamped = pitch_side.clamped;

    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_valid == pitch_valid && yaw_valid == roll_valid)
        else $error("angle pipelines out of step");

    a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_valid && pitch_side.clamped |-> pitch == Q_CODE || pitch == -Q_CODE)
        else $error("clamped pitch not at quarter turn");

    a_no_side: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_valid |-> !yaw_side.clamped && !roll_side.clamped)
        else $error("clamp flag on yaw or roll");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        quat_in.valid && quat_in.ready |=> u_products.prod_valid_reg)
        else $error("accepted item not captured");

endmodule
